@@ sv/esr_pkg.sv @@
`default_nettype none
package esr_pkg;
    localparam int CoordBits  = 12;
    localparam int RadiusBits = 10;
    localparam int OutBits    = 13;
    localparam int ColourBits = 24;

    typedef enum logic [0:0] {
        REQ_START = 1'b0,
        REQ_ROW   = 1'b1
    } req_t;
endpackage
`default_nettype wire

@@ sv/esr_front.sv @@
`default_nettype none
// Front end: holds accepted requests in a two-entry queue so the back end
// can stall independently of the input.
module esr_front
    import esr_pkg::*;
#(
    parameter int W = 70
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         in_valid,
    output logic              in_ready,
    input  wire logic [W-1:0] in_data,
    output logic              q_valid,
    input  wire logic         q_ready,
    output logic [W-1:0]      q_data
);
    logic [W-1:0] mem_reg [2];
    logic         wp_reg, wp_next, rp_reg, rp_next;
    logic [1:0]   cnt_reg, cnt_next;
    logic         push, pop;

    assign in_ready = (cnt_reg != 2'd2);
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_data   = mem_reg[rp_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    always_comb
    begin
        wp_next  = push ? ~wp_reg : wp_reg;
        rp_next  = pop ? ~rp_reg : rp_reg;
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wp_reg] <= in_data;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) cnt_reg != 2'd3)
        else $error("queue count overflow");
    assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'd2 && !pop) |=> cnt_reg == 2'd2)
        else $error("full queue lost an entry");
    assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'd0 && !push) |=> cnt_reg == 2'd0)
        else $error("empty queue gained an entry");
endmodule
`default_nettype wire

@@ sv/esr_back.sv @@
`default_nettype none
// Back end: latches the ellipse on a start, runs the downward half-span
// search one candidate at a time, then emits up to four spans.
module esr_back
    import esr_pkg::*;
#(
    parameter int CB = CoordBits,
    parameter int RB = RadiusBits
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  q_valid,
    output logic                       q_ready,
    input  wire logic                  q_req,
    input  wire logic signed [CB-1:0]  q_cx,
    input  wire logic signed [CB-1:0]  q_cy,
    input  wire logic [RB-1:0]         q_hw,
    input  wire logic [RB-1:0]         q_hh,
    input  wire logic                  q_fill,
    input  wire logic [ColourBits-1:0] q_colour,
    output logic                       o_valid,
    input  wire logic                  o_ready,
    output logic [OutBits-1:0]         o_row,
    output logic [OutBits-1:0]         o_xs,
    output logic [OutBits-1:0]         o_xe,
    output logic [ColourBits-1:0]      o_colour,
    output logic                       o_span_valid,
    output logic                       o_last,
    output logic                       o_done
);
    localparam int XB = RB + 1;
    localparam int SB = 2 * RB;
    localparam int PB = 4 * RB + 2;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_SQ   = 5'b00010,
        ST_MUL  = 5'b00100,
        ST_TEST = 5'b01000,
        ST_EMIT = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    logic signed [CB-1:0] ccol_reg, crow_reg;
    logic [RB-1:0] hw_reg, hh_reg;
    logic [SB-1:0] wsq_reg, hsq_reg;
    logic [PB-1:0] area_reg, yterm_reg, xterm_reg;
    logic [SB+1:0] xsq_reg, ysq_reg;
    logic [XB-1:0] x0_reg, x1_reg;
    // The slope guess is signed: the half span can grow by one in outline mode.
    logic [XB:0] dx_reg;
    logic [XB-1:0] y_reg;
    logic solid_reg, active_reg, lastrow_reg;
    logic [ColourBits-1:0] col_reg;
    logic [1:0] k_reg, nres;
    logic phase_reg;
    logic start_reg;

    logic s_ok;
    logic search_step;

    logic out_free;
    assign out_free = !o_valid || o_ready;
    assign q_ready  = (state_reg == ST_IDLE) && out_free;

    logic [XB+1:0] guess;
    logic signed [XB+1:0] guess_s;
    logic [XB-1:0] x1_init;
    always_comb
    begin
        guess_s = $signed({2'b00, x0_reg}) - $signed({dx_reg[XB], dx_reg})
                  + $signed((XB+2)'(1));
        guess   = guess_s;
        if (guess_s < 0)
            x1_init = '0;
        else if (guess_s > $signed({3'b000, hw_reg}))
            x1_init = {1'b0, hw_reg};
        else
            x1_init = guess[XB-1:0];
    end

    assign search_step = phase_reg && (x1_reg != '0) && (xterm_reg + yterm_reg > area_reg);

    logic signed [OutBits-1:0] cc, cr, top, bot, ox0, ox1;
    always_comb
    begin
        cc  = OutBits'(ccol_reg);
        cr  = OutBits'(crow_reg);
        top = cr - OutBits'($signed({1'b0, y_reg}));
        bot = cr + OutBits'($signed({1'b0, y_reg}));
        ox0 = OutBits'($signed({1'b0, x0_reg}));
        ox1 = OutBits'($signed({1'b0, x1_reg}));
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (q_valid && out_free)
                    state_next = (q_req == REQ_START || active_reg) ? ST_SQ : ST_EMIT;
            ST_SQ:   state_next = start_reg ? ST_EMIT : ST_MUL;
            ST_MUL:  state_next = ST_TEST;
            ST_TEST:
                if (phase_reg && !search_step)
                    state_next = ST_EMIT;
            ST_EMIT:
                if (out_free && k_reg == nres)
                    state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            active_reg <= 1'b0;
            o_valid    <= 1'b0;
            ccol_reg <= '0; crow_reg <= '0; hw_reg <= '0; hh_reg <= '0;
            wsq_reg <= '0; hsq_reg <= '0; area_reg <= '0;
            x0_reg <= '0; dx_reg <= '0; y_reg <= '0;
            solid_reg <= 1'b0; col_reg <= '0;
            x1_reg <= '0; xsq_reg <= '0; ysq_reg <= '0;
            xterm_reg <= '0; yterm_reg <= '0;
            k_reg <= '0; phase_reg <= 1'b0; start_reg <= 1'b0; lastrow_reg <= 1'b0;
            o_row <= '0; o_xs <= '0; o_xe <= '0; o_colour <= '0;
            o_span_valid <= 1'b0; o_last <= 1'b0; o_done <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (o_ready && state_reg != ST_EMIT)
                o_valid <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                    if (q_valid && out_free)
                    begin
                        k_reg <= 2'd0;
                        if (q_req == REQ_START)
                        begin
                            start_reg <= 1'b1;
                            ccol_reg  <= q_cx;
                            crow_reg  <= q_cy;
                            hw_reg    <= q_hw;
                            hh_reg    <= q_hh;
                            solid_reg <= q_fill;
                            col_reg   <= q_colour;
                            x0_reg    <= XB'(q_hw);
                            dx_reg    <= '0;
                            y_reg     <= '0;
                            wsq_reg   <= SB'(q_hw * q_hw);
                            hsq_reg   <= SB'(q_hh * q_hh);
                        end
                        else
                        begin
                            start_reg <= 1'b0;
                            if (active_reg)
                            begin
                                y_reg     <= y_reg + 1'b1;
                                phase_reg <= 1'b0;
                            end
                        end
                    end
                ST_SQ:
                begin
                    area_reg <= PB'(wsq_reg * hsq_reg);
                    if (!start_reg)
                        ysq_reg <= (SB+2)'(y_reg * y_reg);
                end
                ST_MUL:
                begin
                    yterm_reg <= PB'(ysq_reg * wsq_reg);
                    x1_reg    <= x1_init;
                    xsq_reg   <= (SB+2)'(x1_init * x1_init);
                    phase_reg <= 1'b0;
                end
                ST_TEST:
                    if (!phase_reg)
                    begin
                        xterm_reg <= PB'(xsq_reg * hsq_reg);
                        phase_reg <= 1'b1;
                    end
                    else if (search_step)
                    begin
                        x1_reg    <= x1_reg - 1'b1;
                        xsq_reg   <= (SB+2)'((x1_reg - 1'b1) * (x1_reg - 1'b1));
                        phase_reg <= 1'b0;
                    end
                    else
                    begin
                        // Search settled: prepare span list.
                        dx_reg      <= {1'b0, x0_reg} - {1'b0, x1_reg};
                        lastrow_reg <= ({1'b0, y_reg} >= {2'b00, hh_reg});
                        if (!solid_reg)
                        begin
                            if (x0_reg > x1_reg + 1'b1)
                                x0_reg <= x0_reg - 1'b1;
                            else
                                x1_reg <= x1_reg + 1'b1;
                        end
                    end
                ST_EMIT:
                    if (out_free)
                    begin
                        o_valid  <= 1'b1;
                        o_colour <= col_reg;
                        o_span_valid <= 1'b1;
                        o_last   <= (k_reg == nres);
                        o_done   <= 1'b0;
                        k_reg    <= k_reg + 1'b1;
                        if (start_reg)
                        begin
                            o_row <= cr;
                            o_xs  <= (solid_reg || k_reg == 2'd0) ? cc - ox0 : cc + ox0;
                            o_xe  <= (solid_reg || k_reg != 2'd0) ? cc + ox0 : cc - ox0;
                            if (k_reg == nres)
                            begin
                                active_reg <= (hh_reg != '0);
                                o_done     <= (hh_reg == '0);
                            end
                        end
                        else if (!active_reg)
                        begin
                            o_row <= '0; o_xs <= '0; o_xe <= '0;
                            o_colour <= '0; o_span_valid <= 1'b0;
                        end
                        else
                        begin
                            o_row <= k_reg[0] ? bot : top;
                            if (solid_reg)
                            begin
                                o_xs <= cc - ox1; o_xe <= cc + ox1;
                            end
                            else if (!s_ok)
                            begin
                                o_xs <= '0; o_xe <= '0; o_span_valid <= 1'b0;
                            end
                            else if (!k_reg[1])
                            begin
                                o_xs <= cc - ox0; o_xe <= cc - ox1 - 1'b1;
                            end
                            else
                            begin
                                o_xs <= cc + ox1; o_xe <= cc + ox0 - 1'b1;
                            end
                            if (k_reg == nres)
                            begin
                                o_done <= lastrow_reg;
                                x0_reg <= x1_reg;
                                if (lastrow_reg)
                                    active_reg <= 1'b0;
                            end
                        end
                    end
                default: ;
            endcase
        end
    end

    // Index of the last result in the coming emission (result count minus one).
    always_comb
    begin
        if (start_reg)
            nres = solid_reg ? 2'd0 : 2'd1;
        else if (!active_reg)
            nres = 2'd0;
        else if (solid_reg)
            nres = 2'd1;
        else
            nres = s_ok ? 2'd3 : 2'd0;
    end
    assign s_ok = x0_reg > x1_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        (o_valid && !o_ready) |=> o_valid)
        else $error("result dropped while stalled");
    assert property (@(posedge clk) disable iff (!rst_n)
        (o_valid && o_done) |-> o_last)
        else $error("shape end not on last result");
    assert property (@(posedge clk) disable iff (!rst_n)
        q_ready |-> state_reg == ST_IDLE)
        else $error("request taken while busy");
endmodule
`default_nettype wire

@@ sv/ellipse_span_rasterizer_unit.sv @@
`default_nettype none
// Channel  | Direction | tdata                                        | tuser
// s_axis   | in        | cx[11:0] cy[23:12] hw[33:24] hh[43:34]       | req_type
//          |           | fill[44] colour[68:45]                       |
// m_axis   | out       | row[12:0] xs[25:13] xe[38:26] col[62:39]     | span_valid,
//          |           | done[63]                                     | tlast=last
// Each transaction is first registered in the two-entry input queue. A start
// then goes through SQ to EMIT (one or two results). A next row on an active
// ellipse goes through SQ, MUL and TEST (the downward half-span search), then
// EMIT (one to four results); an idle block goes straight to EMIT. Reset is
// asynchronous, active low. Output stalls hold the back end; the queue still fills.
module ellipse_span_rasterizer_unit
    import esr_pkg::*;
#(
    parameter int COORD_BITS  = CoordBits,
    parameter int RADIUS_BITS = RadiusBits
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // center_x, center_y, half_width, half_height, fill_mode, colour, zero pad
    input  wire logic [((2*COORD_BITS+2*RADIUS_BITS+25+7)/8)*8-1:0] s_axis_tdata,
    // req_type
    input  wire logic        s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // row_y, span_x_start, span_x_end, span_colour, shape_done
    output logic [63:0]      m_axis_tdata,
    // span_valid
    output logic             m_axis_tuser,
    output logic             m_axis_tlast
);
    localparam int FB = 2 * COORD_BITS + 2 * RADIUS_BITS + 25;
    localparam int QW = FB + 1;

    logic q_valid, q_ready;
    logic [QW-1:0] q_data;

    esr_front #(.W(QW)) u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
        .in_data({s_axis_tdata[FB-1:0], s_axis_tuser}),
        .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data)
    );

    logic [OutBits-1:0] row, xs, xe;
    logic [ColourBits-1:0] col;
    logic done;

    esr_back #(.CB(COORD_BITS), .RB(RADIUS_BITS)) u_back (
        .clk(clk), .rst_n(rst_n),
        .q_valid(q_valid), .q_ready(q_ready),
        .q_req(q_data[0]),
        .q_cx(q_data[COORD_BITS:1]),
        .q_cy(q_data[2*COORD_BITS:COORD_BITS+1]),
        .q_hw(q_data[2*COORD_BITS+RADIUS_BITS:2*COORD_BITS+1]),
        .q_hh(q_data[2*COORD_BITS+2*RADIUS_BITS:2*COORD_BITS+RADIUS_BITS+1]),
        .q_fill(q_data[2*COORD_BITS+2*RADIUS_BITS+1]),
        .q_colour(q_data[QW-1:QW-ColourBits]),
        .o_valid(m_axis_tvalid), .o_ready(m_axis_tready),
        .o_row(row), .o_xs(xs), .o_xe(xe), .o_colour(col),
        .o_span_valid(m_axis_tuser), .o_last(m_axis_tlast), .o_done(done)
    );

    assign m_axis_tdata = {done, col, xe, xs, row};
endmodule
`default_nettype wire
